[sv/bqc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bqc_pkg
// Shared constants and types of the biquad cascade filter unit.
// ---------------------------------------------------------------------------
package bqc_pkg;

    localparam int MAX_SECTIONS = 8;
    localparam int MAX_CHANNELS = 8;

    localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int NS_W       = 4;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int CIDX_W     = 6;
    localparam int COEF_W     = 24;
    localparam int HIST_W     = 32;
    localparam int PROD_W     = HIST_W + COEF_W;
    localparam int ACC_W      = PROD_W + 4;

    localparam int COEF_DEPTH = 5 * MAX_SECTIONS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int HIST_DEPTH = 2 * MAX_SECTIONS * MAX_CHANNELS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;
    localparam int ACT_W      = 2;

    // coefficient slots within one section
    localparam int SLOT_A2 = 0;
    localparam int SLOT_A3 = 1;
    localparam int SLOT_B1 = 2;
    localparam int SLOT_B2 = 3;
    localparam int SLOT_B3 = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_FILTER = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        MUL_MEM = 2'd0,
        MUL_H1  = 2'd1,
        MUL_H2  = 2'd2,
        MUL_W   = 2'd3
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_LOAD_X = 3'd1,
        ACC_SUB    = 3'd2,
        ACC_ADD    = 3'd3,
        ACC_LOAD_P = 3'd4
    } acc_op_t;

    typedef struct packed {
        logic     ld_sample;
        logic     ld_h1;
        logic     ld_h2;
        logic     ld_w;
        logic     ld_x;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
    } dp_ctrl_t;

endpackage
`default_nettype wire

[sv/bqc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bqc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module bqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[sv/bqc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bqc_datapath
// Shared multiplier, accumulator and rounding for one biquad step at a time.
// ---------------------------------------------------------------------------
module bqc_datapath (
    input  wire logic                                   clk,
    input  wire bqc_pkg::dp_ctrl_t                      ctrl,
    input  wire logic signed [bqc_pkg::SAMPLE_W-1:0]    sample,
    input  wire logic signed [bqc_pkg::HIST_W-1:0]      hist_data,
    input  wire logic signed [bqc_pkg::COEF_W-1:0]      coef_data,
    output logic signed      [bqc_pkg::HIST_W-1:0]      h1,
    output logic signed      [bqc_pkg::HIST_W-1:0]      w,
    output logic signed      [bqc_pkg::SAMPLE_W-1:0]    filtered
);

    localparam int AW = bqc_pkg::ACC_W;
    localparam int HW = bqc_pkg::HIST_W;
    localparam int SW = bqc_pkg::SAMPLE_W;

    localparam logic signed [AW-1:0] H_MAX = {{(AW-HW+1){1'b0}}, {(HW-1){1'b1}}};
    localparam logic signed [AW-1:0] H_MIN = {{(AW-HW+1){1'b1}}, {(HW-1){1'b0}}};
    localparam logic signed [HW:0]   S_MAX = {{(HW-SW+2){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [HW:0]   S_MIN = {{(HW-SW+2){1'b1}}, {(SW-1){1'b0}}};

    logic signed [HW-1:0]              h1_reg;
    logic signed [HW-1:0]              h2_reg;
    logic signed [HW-1:0]              w_reg;
    logic signed [HW-1:0]              x_reg;
    logic signed [bqc_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]              acc_reg;
    logic signed [HW-1:0]              mul_a;
    logic signed [AW-1:0]              acc_next;

    // Q.36 sum to Q16.16, round half up, saturate
    function automatic logic signed [HW-1:0] round_hist(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        logic signed [HW-1:0] r;
        t = (v + AW'(1 << 19)) >>> 20;
        if (t > H_MAX)
            r = H_MAX[HW-1:0];
        else if (t < H_MIN)
            r = H_MIN[HW-1:0];
        else
            r = t[HW-1:0];
        return r;
    endfunction

    // Q16.16 to integer sample, round half up, saturate
    function automatic logic signed [SW-1:0] round_out(input logic signed [HW-1:0] v);
        logic signed [HW:0]   t;
        logic signed [SW-1:0] r;
        t = ($signed({v[HW-1], v}) + (HW+1)'(1 << 15)) >>> 16;
        if (t > S_MAX)
            r = S_MAX[SW-1:0];
        else if (t < S_MIN)
            r = S_MIN[SW-1:0];
        else
            r = t[SW-1:0];
        return r;
    endfunction

    always_comb
    begin
        case (ctrl.mul_sel)
            bqc_pkg::MUL_MEM: mul_a = hist_data;
            bqc_pkg::MUL_H1:  mul_a = h1_reg;
            bqc_pkg::MUL_H2:  mul_a = h2_reg;
            bqc_pkg::MUL_W:   mul_a = w_reg;
            default:          mul_a = hist_data;
        endcase
    end

    always_comb
    begin
        case (ctrl.acc_op)
            bqc_pkg::ACC_LOAD_X: acc_next = $signed({{(AW-HW-20){x_reg[HW-1]}}, x_reg, 20'd0});
            bqc_pkg::ACC_SUB:    acc_next = acc_reg - AW'(prod_reg);
            bqc_pkg::ACC_ADD:    acc_next = acc_reg + AW'(prod_reg);
            bqc_pkg::ACC_LOAD_P: acc_next = AW'(prod_reg);
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * coef_data;
        acc_reg  <= acc_next;
        if (ctrl.ld_h1)
        begin
            h1_reg <= hist_data;
        end
        if (ctrl.ld_h2)
        begin
            h2_reg <= hist_data;
        end
        if (ctrl.ld_w)
        begin
            w_reg <= round_hist(acc_reg);
        end
        if (ctrl.ld_sample)
        begin
            x_reg <= $signed({sample, 16'd0});
        end
        else if (ctrl.ld_x)
        begin
            x_reg <= round_hist(acc_reg);
        end
    end

    assign h1       = h1_reg;
    assign w        = w_reg;
    assign filtered = round_out(x_reg);

endmodule
`default_nettype wire

[sv/cascaded_biquad_iir_filter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cascaded_biquad_iir_filter_unit
// Multi-channel cascade of direct form II biquads with one shared multiplier.
// ---------------------------------------------------------------------------
// Input beats (s_*) carry an action in s_tuser: filter a sample of a channel,
// write one coefficient, or clear all history. Write and clear beats finish
// in the cycle they are taken and give no output beat. A filter beat runs the
// sample through num_sections sections (0 counts as 1, above 8 as 8); each
// section runs on the shared 32x24 multiplier and accumulator, which computes
// its five products one per cycle. After the last section the item goes to
// the done state, which loads the filtered sample into m_* once the output
// register is free and returns to idle, where the next input beat is taken.
// s_tready is high only while no item is in work.
// The result sits in an output register (m_*); the next input beat is taken
// while it waits. If the receiver stalls with a result still held, a finished
// item waits until the register frees.
// cfg_* writes num_sections; it is always ready and meant for idle times.
// Reset (rst_n low) sets num_sections to 1 and clears all history at once
// through per-word valid bits; coefficients must be written before use.
// ---------------------------------------------------------------------------
module cascaded_biquad_iir_filter_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] channel, [18:3] sample, [24:19] coef_index, [48:25] coef_value
    input  wire logic [bqc_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] action
    input  wire logic [bqc_pkg::ACT_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [15:0] filtered, [18:16] out_channel
    output logic      [bqc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bqc_pkg::NS_W-1:0]          cfg_data
);

    localparam int SEC_W   = bqc_pkg::SEC_W;
    localparam int HIST_AW = bqc_pkg::HIST_AW;
    localparam int COEF_AW = bqc_pkg::COEF_AW;

    localparam logic [2:0] STP_ADDR  = 3'd0;
    localparam logic [2:0] STP_H1    = 3'd1;
    localparam logic [2:0] STP_H2    = 3'd2;
    localparam logic [2:0] STP_B2    = 3'd3;
    localparam logic [2:0] STP_B3    = 3'd4;
    localparam logic [2:0] STP_B1    = 3'd5;
    localparam logic [2:0] STP_ACC   = 3'd6;
    localparam logic [2:0] STP_ROUND = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                             state_reg, state_next;
    logic [2:0]                         step_reg;
    logic [SEC_W-1:0]                   sec_reg;
    logic [bqc_pkg::CH_W-1:0]           ch_reg;
    logic [bqc_pkg::NS_W-1:0]           nsec_reg;
    logic [bqc_pkg::HIST_DEPTH-1:0]     hist_vld_reg;
    logic                               rvld_reg;
    logic                               m_tvalid_reg;
    logic [bqc_pkg::M_TDATA_W-1:0]      m_tdata_reg;

    bqc_pkg::action_t                   act;
    logic [bqc_pkg::CH_W-1:0]           in_channel;
    logic signed [bqc_pkg::SAMPLE_W-1:0] in_sample;
    logic [bqc_pkg::CIDX_W-1:0]         in_cidx;
    logic [bqc_pkg::COEF_W-1:0]         in_cval;
    logic                               s_accept;
    logic                               start_filter;
    logic                               coef_we;
    logic                               do_clear;
    logic [SEC_W-1:0]                   sec_last;
    logic                               out_free;

    logic [HIST_AW-1:0]                 hist_base;
    logic [HIST_AW-1:0]                 hist_raddr;
    logic [HIST_AW-1:0]                 hist_waddr;
    logic                               hist_we;
    logic [bqc_pkg::HIST_W-1:0]         hist_wdata;
    logic [bqc_pkg::HIST_W-1:0]         hist_rdata;
    logic signed [bqc_pkg::HIST_W-1:0]  hist_data;
    logic [COEF_AW-1:0]                 coef_raddr;
    logic [COEF_AW-1:0]                 coef_base;
    logic [bqc_pkg::COEF_W-1:0]         coef_rdata;
    int                                 slot;

    bqc_pkg::dp_ctrl_t                  ctrl;
    logic signed [bqc_pkg::HIST_W-1:0]  dp_h1;
    logic signed [bqc_pkg::HIST_W-1:0]  dp_w;
    logic signed [bqc_pkg::SAMPLE_W-1:0] dp_filtered;

    assign act        = bqc_pkg::action_t'(s_tuser);
    assign in_channel = s_tdata[2:0];
    assign in_sample  = $signed(s_tdata[18:3]);
    assign in_cidx    = s_tdata[24:19];
    assign in_cval    = s_tdata[48:25];

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign start_filter = s_accept && (act == bqc_pkg::ACT_FILTER)
                          && (32'(in_channel) < bqc_pkg::MAX_CHANNELS);
    assign coef_we      = s_accept && (act == bqc_pkg::ACT_WRITE)
                          && (32'(in_cidx) < bqc_pkg::COEF_DEPTH);
    assign do_clear     = s_accept && (act == bqc_pkg::ACT_CLEAR);
    assign out_free     = !m_tvalid_reg || m_tready;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        if (nsec_reg == '0)
            sec_last = '0;
        else if (32'(nsec_reg) > bqc_pkg::MAX_SECTIONS)
            sec_last = SEC_W'(bqc_pkg::MAX_SECTIONS - 1);
        else
            sec_last = SEC_W'(nsec_reg - 1'b1);
    end

    // address generation
    always_comb
    begin
        hist_base = HIST_AW'((int'(ch_reg) * bqc_pkg::MAX_SECTIONS + int'(sec_reg)) * 2);
        coef_base = COEF_AW'(int'(sec_reg) * 5);
        hist_raddr = hist_base;
        hist_waddr = hist_base;
        hist_we    = 1'b0;
        hist_wdata = dp_w;
        slot       = bqc_pkg::SLOT_A2;
        ctrl       = '{ld_sample: start_filter, ld_h1: 1'b0, ld_h2: 1'b0, ld_w: 1'b0,
                       ld_x: 1'b0, mul_sel: bqc_pkg::MUL_MEM, acc_op: bqc_pkg::ACC_HOLD};
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                STP_ADDR:
                begin
                    slot = bqc_pkg::SLOT_A2;
                end
                STP_H1:
                begin
                    hist_raddr   = hist_base | HIST_AW'(1);
                    slot         = bqc_pkg::SLOT_A3;
                    ctrl.ld_h1   = 1'b1;
                    ctrl.mul_sel = bqc_pkg::MUL_MEM;
                    ctrl.acc_op  = bqc_pkg::ACC_LOAD_X;
                end
                STP_H2:
                begin
                    slot         = bqc_pkg::SLOT_B2;
                    ctrl.ld_h2   = 1'b1;
                    ctrl.mul_sel = bqc_pkg::MUL_MEM;
                    ctrl.acc_op  = bqc_pkg::ACC_SUB;
                end
                STP_B2:
                begin
                    slot         = bqc_pkg::SLOT_B3;
                    ctrl.mul_sel = bqc_pkg::MUL_H1;
                    ctrl.acc_op  = bqc_pkg::ACC_SUB;
                end
                STP_B3:
                begin
                    slot         = bqc_pkg::SLOT_B1;
                    ctrl.mul_sel = bqc_pkg::MUL_H2;
                    ctrl.ld_w    = 1'b1;
                    ctrl.acc_op  = bqc_pkg::ACC_LOAD_P;
                    hist_we      = 1'b1;
                    hist_waddr   = hist_base | HIST_AW'(1);
                    hist_wdata   = dp_h1;
                end
                STP_B1:
                begin
                    ctrl.mul_sel = bqc_pkg::MUL_W;
                    ctrl.acc_op  = bqc_pkg::ACC_ADD;
                    hist_we      = 1'b1;
                    hist_wdata   = dp_w;
                end
                STP_ACC:
                begin
                    ctrl.acc_op  = bqc_pkg::ACC_ADD;
                end
                STP_ROUND:
                begin
                    ctrl.ld_x    = 1'b1;
                end
                default:
                begin
                    ctrl.acc_op  = bqc_pkg::ACC_HOLD;
                end
            endcase
        end
        coef_raddr = coef_base + COEF_AW'(slot);
    end

    assign hist_data = rvld_reg ? $signed(hist_rdata) : '0;

    bqc_ram #(
        .WIDTH (bqc_pkg::COEF_W),
        .DEPTH (bqc_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (COEF_AW'(in_cidx)),
        .wdata (in_cval),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqc_ram #(
        .WIDTH (bqc_pkg::HIST_W),
        .DEPTH (bqc_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    bqc_datapath u_datapath (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (in_sample),
        .hist_data (hist_data),
        .coef_data ($signed(coef_rdata)),
        .h1        (dp_h1),
        .w         (dp_w),
        .filtered  (dp_filtered)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_filter)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step_reg == STP_ROUND && sec_reg == sec_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STP_ADDR;
            sec_reg      <= '0;
            ch_reg       <= '0;
            nsec_reg     <= bqc_pkg::NS_W'(1);
            hist_vld_reg <= '0;
            rvld_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rvld_reg  <= hist_vld_reg[hist_raddr];
            if (cfg_valid && cfg_ready)
            begin
                nsec_reg <= cfg_data;
            end
            if (do_clear)
            begin
                hist_vld_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_vld_reg[hist_waddr] <= 1'b1;
            end
            if (start_filter)
            begin
                ch_reg   <= in_channel;
                sec_reg  <= '0;
                step_reg <= STP_ADDR;
            end
            else if (state_reg == ST_RUN)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == STP_ROUND && sec_reg != sec_last)
                begin
                    sec_reg <= sec_reg + 1'b1;
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            m_tdata_reg <= {5'd0, ch_reg, dp_filtered};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_hist_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |-> (state_reg == ST_RUN))
        else $error("history written outside a filter run");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (hist_vld_reg == '0))
        else $error("history not cleared");

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start_filter |=> (step_reg == STP_ADDR && sec_reg == '0 && state_reg == ST_RUN))
        else $error("filter run did not start at first section");

    a_sec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (sec_reg <= sec_last))
        else $error("section counter beyond last section");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output beat without finished item");

endmodule
`default_nettype wire

[sim/tb_cascaded_biquad_iir_filter_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cascaded_biquad_iir_filter_unit
// Self-checking bench for the multi-channel biquad cascade filter unit.
// A fixed-point cascade predictor tracks coefficients, per-channel history
// and the section count, and queues the filtered sample due for each accepted
// filter beat. Output beats are checked field by field in order. Stimulus:
// coefficient load, directed edge cases, a sweep of section counts with
// random traffic under random idling on both sides, and a long output stall.
// ---------------------------------------------------------------------------
module tb_cascaded_biquad_iir_filter_unit;
    import bqc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 80;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int SWEEP_PHASES     = 12;
    localparam int MAX_REPORTS      = 10;
    localparam int Q_ONE            = 1 << 20;
    localparam int A_LIMIT          = 471859;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [COEF_W-1:0]   COEF_MAX   = 24'sh7FFFFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = 24'sh800000;
    localparam longint HIST_MAX = 64'sd2147483647;
    localparam longint HIST_MIN = -64'sd2147483648;
    localparam int     S_FIELDS_W = CH_W + SAMPLE_W + CIDX_W + COEF_W;

    typedef struct {
        logic signed [SAMPLE_W-1:0] filtered;
        logic [CH_W-1:0]            channel;
    } filt_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [ACT_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [NS_W-1:0]        cfg_data  = '0;

    logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
    logic signed [HIST_W-1:0] hist_mem [HIST_DEPTH];
    logic [NS_W-1:0]          sections_cfg = 4'd1;
    filt_result_t             pending_results [$];

    int tx_idle_max    = 10;
    int rx_idle_max    = 10;
    int rx_hold_left   = 0;
    int mismatch_count = 0;

    cascaded_biquad_iir_filter_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #(30_000_000);
        $display("FAIL");
        $finish;
    end

    // Q.36 sum -> saturated Q16.16, round half up
    function automatic logic signed [HIST_W-1:0] round_q16(input longint acc);
        longint r;
        r = (acc + (longint'(1) <<< 19)) >>> 20;
        if (r > HIST_MAX)
            r = HIST_MAX;
        else if (r < HIST_MIN)
            r = HIST_MIN;
        return r[HIST_W-1:0];
    endfunction

    task automatic run_cascade(input logic [CH_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] smp,
                               output logic signed [SAMPLE_W-1:0] y);
        longint x, w, h1, h2, acc;
        int used, base, hb, s;
        used = (sections_cfg == 0) ? 1 :
               ((sections_cfg > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections_cfg));
        x = longint'(smp) <<< 16;
        for (s = 0; s < used; s++)
        begin
            base = s * 5;
            hb   = (int'(ch) * MAX_SECTIONS + s) * 2;
            h1   = hist_mem[hb];
            h2   = hist_mem[hb + 1];
            acc  = (x <<< 20) - h1 * coef_mem[base + SLOT_A2] - h2 * coef_mem[base + SLOT_A3];
            w    = round_q16(acc);
            acc  = w * coef_mem[base + SLOT_B1] + h1 * coef_mem[base + SLOT_B2]
                 + h2 * coef_mem[base + SLOT_B3];
            x    = round_q16(acc);
            hist_mem[hb + 1] = h1[HIST_W-1:0];
            hist_mem[hb]     = w[HIST_W-1:0];
        end
        acc = (x + 32768) >>> 16;
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        y = acc[SAMPLE_W-1:0];
    endtask

    task automatic track_beat(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] smp,
                              input logic [CIDX_W-1:0] cidx,
                              input logic signed [COEF_W-1:0] cval);
        filt_result_t res;
        case (act)
            ACT_FILTER:
            begin
                if (ch < MAX_CHANNELS)
                begin
                    run_cascade(ch, smp, res.filtered);
                    res.channel = ch;
                    pending_results.push_back(res);
                end
            end
            ACT_WRITE:
            begin
                if (cidx < COEF_DEPTH)
                    coef_mem[cidx] = cval;
            end
            ACT_CLEAR:
            begin
                foreach (hist_mem[i])
                    hist_mem[i] = '0;
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic [CIDX_W-1:0] cidx,
                             input logic signed [COEF_W-1:0] cval);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, cval, cidx, smp, ch};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        track_beat(act, ch, smp, cidx, cval);
    endtask

    // block is idle once all results are out and the last item has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sections(input logic [NS_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sections_cfg = value;
    endtask

    // |a2| + |a3| < 1 keeps each section stable
    function automatic logic signed [COEF_W-1:0] mild_coef(input int slot);
        if (slot == SLOT_A2 || slot == SLOT_A3)
            return COEF_W'(int'($urandom_range(0, 2 * A_LIMIT)) - A_LIMIT);
        return COEF_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 19))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return -16'sd1;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic random_beat(output bit counted);
        int pick;
        logic [ACT_W-1:0] act;
        logic [CIDX_W-1:0] idx;
        logic signed [COEF_W-1:0] cval;
        pick = $urandom_range(0, 99);
        if (pick < 82)
            act = ACT_FILTER;
        else if (pick < 92)
            act = ACT_WRITE;
        else if (pick < 96)
            act = ACT_CLEAR;
        else
            act = ACT_UNUSED;
        idx  = ($urandom_range(0, 9) == 0) ? CIDX_W'($urandom_range(0, 63))
                                           : CIDX_W'($urandom_range(0, COEF_DEPTH - 1));
        cval = ($urandom_range(0, 9) == 0) ? COEF_W'($urandom()) : mild_coef(int'(idx) % 5);
        send_beat(act, CH_W'($urandom()), random_sample(), idx, cval);
        counted = (act != ACT_UNUSED) && !(act == ACT_WRITE && idx >= COEF_DEPTH);
    endtask

    task automatic test_coef_load();
        int i;
        for (i = 0; i < COEF_DEPTH; i++)
            send_beat(ACT_WRITE, CH_W'($urandom()), random_sample(), CIDX_W'(i),
                      mild_coef(i % 5));
    endtask

    // runs on the reset section count
    task automatic test_edge_cases();
        send_beat(ACT_FILTER, 0, SAMPLE_MAX, 0, 0);
        send_beat(ACT_FILTER, 7, SAMPLE_MIN, 0, 0);
        send_beat(ACT_FILTER, 0, -1, 0, 0);
        send_beat(ACT_FILTER, 7, 1, 0, 0);
        send_beat(ACT_FILTER, 0, 0, 0, 0);
        // ignored: unused action, index past the coefficient store
        send_beat(ACT_UNUSED, 5, SAMPLE_MAX, 0, COEF_MAX);
        send_beat(ACT_WRITE, 2, 0, COEF_DEPTH, COEF_MAX);
        send_beat(ACT_WRITE, 2, 0, 6'h3F, COEF_MIN);
        send_beat(ACT_FILTER, 2, 16'sd12345, 0, 0);
        // overdriven section 0 saturates history and output both ways
        send_beat(ACT_WRITE, 0, 0, SLOT_A2, COEF_MIN);
        send_beat(ACT_WRITE, 0, 0, SLOT_B1, COEF_MAX);
        repeat (3) send_beat(ACT_FILTER, 3, SAMPLE_MAX, 0, 0);
        repeat (3) send_beat(ACT_FILTER, 3, SAMPLE_MIN, 0, 0);
        send_beat(ACT_CLEAR, 3, 0, 0, 0);
        send_beat(ACT_FILTER, 3, 16'sd1000, 0, 0);
        send_beat(ACT_WRITE, 0, 0, SLOT_A2, mild_coef(SLOT_A2));
        send_beat(ACT_WRITE, 0, 0, SLOT_B1, mild_coef(SLOT_B1));
        send_beat(ACT_FILTER, 3, -16'sd1000, 0, 0);
    endtask

    task automatic test_section_sweep();
        int p, done;
        bit counted;
        logic [NS_W-1:0] setting;
        for (p = 0; p < SWEEP_PHASES; p++)
        begin
            case (p)
                1:  setting = 4'd8;
                2:  setting = 4'd0;
                3:  setting = 4'd15;
                4:  setting = 4'd3;
                5:  setting = 4'd9;
                6:  setting = 4'd2;
                7:  setting = 4'd5;
                8:  setting = 4'd7;
                9:  setting = 4'd4;
                10: setting = 4'd6;
                default: setting = 4'd1;
            endcase
            if (p > 0)
                set_sections(setting);
            tx_idle_max = (p % 4 == 1) ? 0 : 10;
            rx_idle_max = tx_idle_max;
            done = 0;
            while (done < RANDOM_PER_PHASE)
            begin
                random_beat(counted);
                if (counted)
                    done++;
            end
        end
        tx_idle_max = 10;
        rx_idle_max = 10;
    endtask

    task automatic test_output_backpressure();
        int i;
        rx_hold_left <= HOLD_CYCLES;
        tx_idle_max = 0;
        for (i = 0; i < 40; i++)
            send_beat(ACT_FILTER, CH_W'($urandom()), random_sample(), 0, 0);
        tx_idle_max = 10;
    endtask

    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = $urandom_range(0, rx_idle_max);
            if (gap > 0 || rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold_left > 0)
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid);
            @(posedge clk);
        end
    end

    // outputs are stable from negedge to the accepting edge
    always @(negedge clk)
    begin
        filt_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected output beat: filtered %0d channel %0d",
                             $signed(m_tdata[15:0]), m_tdata[18:16]);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.filtered)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch filtered: expected %0d, got %0d",
                                 want.filtered, $signed(m_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_tdata[18:16] !== want.channel)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch out_channel: expected %0d, got %0d",
                                 want.channel, m_tdata[18:16]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_coef_load();
        test_edge_cases();
        test_section_sweep();
        test_output_backpressure();
        wait_idle();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
